FILE: sv/cstp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstp_pkg: shared types, constants and datapath step functions
// Register map, fixed-point widths and the single-step square root and
// division functions used by the front and back pipelines.
// ----------------------------------------------------------------------------
package cstp_pkg;

  localparam int InW       = 16;
  localparam int KW        = 32;
  localparam int PosW      = 48;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam int RayW      = 52;
  localparam int MagW      = 30;
  localparam int UnitW     = 31;
  localparam int SqSteps   = 32;
  localparam int UnitQ     = 31;
  localparam int PosQ      = 48;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  localparam logic [FifoAw:0]   FifoCntMax = (FifoAw + 1)'(FifoDepth);
  localparam logic [PosW-1:0]   PosMax     = {1'b0, {(PosW - 1){1'b1}}};
  localparam logic [PosW-1:0]   PosMin     = {1'b1, {(PosW - 1){1'b0}}};
  localparam logic [RayW-1:0]   ZMag       = RayW'(64'h0000_0001_0000_0000);
  localparam logic [63:0]       OneQ62     = 64'h4000_0000_0000_0000;
  localparam logic [34:0]       CosOne     = 35'h0_8000_0000;

  typedef enum logic [2:0] {
    RegInvK00       = 3'd0,
    RegInvK01       = 3'd1,
    RegInvK02       = 3'd2,
    RegInvK11       = 3'd3,
    RegInvK12       = 3'd4,
    RegSphereRadius = 3'd5,
    RegCosLower     = 3'd6,
    RegCosUpper     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [KW-1:0] inv_k00;
    logic signed [KW-1:0] inv_k01;
    logic signed [KW-1:0] inv_k02;
    logic signed [KW-1:0] inv_k11;
    logic signed [KW-1:0] inv_k12;
    logic [31:0]          sphere_radius;
    logic [31:0]          cos_lower;
    logic [31:0]          cos_upper;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    inv_k00:       32'sd268435,
    inv_k01:       32'sd0,
    inv_k02:       32'hF800_0000,
    inv_k11:       32'sd268435,
    inv_k12:       32'hF800_0000,
    sphere_radius: 32'd65536,
    cos_lower:     32'd674651885,
    cos_upper:     32'd2147454210
  };

  // one ray after normalizing shift: magnitudes and signs of x, y, z
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MagW-1:0]  mag;
  } ray_t;

  // queue entry: classified item waiting for the back end
  typedef struct packed {
    logic                  found;
    logic [31:0]           c;
    logic [2:0]            neg;
    logic [2:0][UnitW-1:0] mag;
  } fq_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [63:0] num;
    logic [31:0] rem;
    logic [47:0] quo;
  } dv_t;

  function automatic sq_t sq_init(logic [63:0] rad);
    sq_t o;
    o.rad  = rad;
    o.rem  = '0;
    o.root = '0;
    return o;
  endfunction

  // one root bit of restoring integer square root
  function automatic sq_t sq_step(sq_t s);
    logic [34:0] r2;
    logic [34:0] trial;
    sq_t o;
    r2    = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of restoring division
  function automatic dv_t dv_step(dv_t s, logic [31:0] den);
    logic [32:0] r2;
    dv_t o;
    r2    = {s.rem, s.num[63]};
    o.num = {s.num[62:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = 32'(r2 - {1'b0, den});
      o.quo = {s.quo[46:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.quo = {s.quo[46:0], 1'b0};
    end
    return o;
  endfunction

  // numerator mag * 2^30, 31 quotient bits
  function automatic dv_t dv_init_unit(logic [MagW-1:0] mag);
    dv_t o;
    o.rem = 32'(mag >> 1);
    o.num = {mag[0], 63'b0};
    o.quo = '0;
    return o;
  endfunction

  // smallest s with v >> s below 2^30
  function automatic logic [4:0] norm_shift(logic [RayW-1:0] v);
    logic [4:0] s;
    s = '0;
    for (int i = MagW; i < RayW; i++) begin
      if (v[i]) begin
        s = 5'(i - MagW + 1);
      end
    end
    return s;
  endfunction

  function automatic logic signed [31:0] apply_sign(logic [UnitW-1:0] m, logic neg);
    logic signed [31:0] v;
    v = signed'({1'b0, m});
    return neg ? -v : v;
  endfunction

endpackage

FILE: sv/cstp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstp_if: circle input and position output stream interfaces
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface cstp_in_if import cstp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [InW-1:0]  centre_x;
  logic [InW-1:0]  centre_y;
  logic [InW-1:0]  circle_radius;

  modport source (output valid, centre_x, centre_y, circle_radius, input ready);
  modport sink   (input valid, centre_x, centre_y, circle_radius, output ready);
endinterface

interface cstp_out_if import cstp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;

  modport source (output valid, found, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, found, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: sv/circle_to_sphere_position_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_to_sphere_position_core: image circle to 3D sphere centre
// Back-projects circle centre and rim point, checks the ray cosine against
// two bounds and scales the centre ray by radius / sine.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        transfer carries
//  in_if     in    valid/ready      centre_x, centre_y, circle_radius (Q12.4)
//  out_if    out   valid/ready      found, pos_x, pos_y, pos_z (Q32.16)
//  apb       in    psel/penable     8 x 32-bit registers, byte addr 4*i
//
//  One transfer per cycle in each direction while out_if is not stalled;
//  fully pipelined datapath. Front: two 32-step square roots, six 31-step
//  dividers; then the queue; back: 32-step sine root, 48-step dividers.
//  Reset (rst_ni, async low) empties the pipes and loads default registers.
//  A stall on out_if freezes the back pipe only; the front keeps taking
//  circles until the 4-entry queue fills.
// ----------------------------------------------------------------------------
module circle_to_sphere_position_core import cstp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  cstp_in_if.sink          in_if,
  cstp_out_if.source       out_if
);

  cfg_t cfg;

  // front -> queue
  logic f_valid, f_ready;
  fq_t  f_data;
  // queue -> back
  logic b_valid, b_ready;
  fq_t  b_data;

  cstp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // rays, unit vectors, cosine and bound test
  cstp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_if     (in_if),
    .q_valid_o (f_valid),
    .q_data_o  (f_data),
    .q_ready_i (f_ready)
  );

  // decouples the two pipelines so each stalls on its own
  cstp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_data),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_data_o   (b_data),
    .pop_ready_i  (b_ready)
  );

  // sine, scaling by sphere radius, saturation
  cstp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (b_valid),
    .q_data_i  (b_data),
    .q_ready_o (b_ready),
    .out_if    (out_if)
  );

endmodule

FILE: sv/cstp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstp_regs: APB configuration registers
// Eight 32-bit registers at word addresses; zero wait states.
// ----------------------------------------------------------------------------
module cstp_regs import cstp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (wr) begin
      unique case (idx)
        RegInvK00:       cfg_q.inv_k00       <= signed'(pwdata);
        RegInvK01:       cfg_q.inv_k01       <= signed'(pwdata);
        RegInvK02:       cfg_q.inv_k02       <= signed'(pwdata);
        RegInvK11:       cfg_q.inv_k11       <= signed'(pwdata);
        RegInvK12:       cfg_q.inv_k12       <= signed'(pwdata);
        RegSphereRadius: cfg_q.sphere_radius <= pwdata;
        RegCosLower:     cfg_q.cos_lower     <= pwdata;
        RegCosUpper:     cfg_q.cos_upper     <= pwdata;
        default:         cfg_q               <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegInvK00:       prdata = unsigned'(cfg_q.inv_k00);
      RegInvK01:       prdata = unsigned'(cfg_q.inv_k01);
      RegInvK02:       prdata = unsigned'(cfg_q.inv_k02);
      RegInvK11:       prdata = unsigned'(cfg_q.inv_k11);
      RegInvK12:       prdata = unsigned'(cfg_q.inv_k12);
      RegSphereRadius: prdata = cfg_q.sphere_radius;
      RegCosLower:     prdata = cfg_q.cos_lower;
      RegCosUpper:     prdata = cfg_q.cos_upper;
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: sv/cstp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstp_front: ray back-projection, normalization and cosine test
// Pipelined; computes both unit rays, their cosine and the bound check.
// ----------------------------------------------------------------------------
module cstp_front import cstp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  cstp_in_if.sink in_if,
  output logic    q_valid_o,
  output fq_t     q_data_o,
  input  logic    q_ready_i
);

  logic en;

  logic signed [KW-1:0] k00, k01, k02, k11, k12;
  logic signed [16:0]   cx_s, cy_s, r_s;

  // a: products
  logic                 a_vld_q;
  logic signed [48:0]   a_pcx_q, a_pr_q, a_pcy01_q, a_pcy11_q;
  // b: centre ray x, y
  logic                 b_vld_q;
  logic signed [RayW-1:0] b_d0_q, b_d1_q, b_pr_q;
  // c: edge ray x
  logic                 c_vld_q;
  logic signed [RayW-1:0] c_d0_q, c_t0_q, c_d1_q;
  // d: magnitudes
  logic                 d_vld_q;
  logic [RayW-1:0]      d_mdx_q, d_mtx_q, d_my_q;
  logic                 d_ndx_q, d_ntx_q, d_ny_q;
  // e: shift counts
  logic                 e_vld_q;
  logic [RayW-1:0]      e_mdx_q, e_mtx_q, e_my_q;
  logic                 e_ndx_q, e_ntx_q, e_ny_q;
  logic [4:0]           e_sd_q, e_st_q;
  // f: shifted rays
  logic                 f_vld_q;
  ray_t                 f_rd_q, f_rt_q;
  // g: squares
  logic                 g_vld_q;
  logic [59:0]          g_sqd_q [3];
  logic [59:0]          g_sqt_q [3];
  ray_t                 g_rd_q, g_rt_q;
  // h: sums of squares
  logic                 h_vld_q;
  logic [61:0]          h_sumd_q, h_sumt_q;
  ray_t                 h_rd_q, h_rt_q;

  // square root
  logic [SqSteps-1:0]   sq_vld_q;
  sq_t                  sqd_q [SqSteps];
  sq_t                  sqt_q [SqSteps];
  ray_t                 sq_rd_q [SqSteps];
  ray_t                 sq_rt_q [SqSteps];

  // unit division, lanes 0..2 centre ray, 3..5 edge ray
  logic [UnitQ-1:0]     ud_vld_q;
  dv_t                  udv_q  [UnitQ][6];
  logic [31:0]          uden_q [UnitQ][6];
  logic [5:0]           uneg_q [UnitQ];

  // i: dot products, j: cosine, k: classification
  logic                 i_vld_q;
  logic signed [63:0]   i_dot_q [3];
  logic [2:0][UnitW-1:0] i_mag_q;
  logic [2:0]           i_neg_q;
  logic                 j_vld_q;
  logic signed [63:0]   j_cos_q;
  logic [2:0][UnitW-1:0] j_mag_q;
  logic [2:0]           j_neg_q;
  logic                 k_vld_q;
  fq_t                  k_q;

  logic signed [63:0]   lo, hi;
  logic [UnitW-1:0]     uq [6];
  logic signed [31:0]   uv [6];

  assign en          = !k_vld_q || q_ready_i;
  assign in_if.ready = en;
  assign q_valid_o   = k_vld_q;
  assign q_data_o    = k_q;

  assign k00  = cfg_i.inv_k00;
  assign k01  = cfg_i.inv_k01;
  assign k02  = cfg_i.inv_k02;
  assign k11  = cfg_i.inv_k11;
  assign k12  = cfg_i.inv_k12;
  assign cx_s = signed'({1'b0, in_if.centre_x});
  assign cy_s = signed'({1'b0, in_if.centre_y});
  assign r_s  = signed'({1'b0, in_if.circle_radius});
  assign lo   = signed'({3'b000, cfg_i.cos_lower, 29'b0});
  assign hi   = signed'({3'b000, cfg_i.cos_upper, 29'b0});

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      uq[l] = udv_q[UnitQ-1][l].quo[UnitW-1:0];
      uv[l] = apply_sign(uq[l], uneg_q[UnitQ-1][l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      e_vld_q  <= 1'b0;
      f_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      h_vld_q  <= 1'b0;
      sq_vld_q <= '0;
      ud_vld_q <= '0;
      i_vld_q  <= 1'b0;
      j_vld_q  <= 1'b0;
      k_vld_q  <= 1'b0;
    end else if (en) begin
      a_vld_q  <= in_if.valid;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      d_vld_q  <= c_vld_q;
      e_vld_q  <= d_vld_q;
      f_vld_q  <= e_vld_q;
      g_vld_q  <= f_vld_q;
      h_vld_q  <= g_vld_q;
      sq_vld_q <= {sq_vld_q[SqSteps-2:0], h_vld_q};
      ud_vld_q <= {ud_vld_q[UnitQ-2:0], sq_vld_q[SqSteps-1]};
      i_vld_q  <= ud_vld_q[UnitQ-1];
      j_vld_q  <= i_vld_q;
      k_vld_q  <= j_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pcx_q   <= cx_s * k00;
      a_pr_q    <= r_s * k00;
      a_pcy01_q <= cy_s * k01;
      a_pcy11_q <= cy_s * k11;

      b_d0_q <= RayW'(a_pcx_q) + RayW'(a_pcy01_q) + (RayW'(k02) <<< 4);
      b_d1_q <= RayW'(a_pcy11_q) + (RayW'(k12) <<< 4);
      b_pr_q <= RayW'(a_pr_q);

      c_d0_q <= b_d0_q;
      c_t0_q <= b_d0_q + b_pr_q;
      c_d1_q <= b_d1_q;

      d_mdx_q <= c_d0_q[RayW-1] ? unsigned'(-c_d0_q) : unsigned'(c_d0_q);
      d_mtx_q <= c_t0_q[RayW-1] ? unsigned'(-c_t0_q) : unsigned'(c_t0_q);
      d_my_q  <= c_d1_q[RayW-1] ? unsigned'(-c_d1_q) : unsigned'(c_d1_q);
      d_ndx_q <= c_d0_q[RayW-1];
      d_ntx_q <= c_t0_q[RayW-1];
      d_ny_q  <= c_d1_q[RayW-1];

      e_mdx_q <= d_mdx_q;
      e_mtx_q <= d_mtx_q;
      e_my_q  <= d_my_q;
      e_ndx_q <= d_ndx_q;
      e_ntx_q <= d_ntx_q;
      e_ny_q  <= d_ny_q;
      e_sd_q  <= norm_shift(d_mdx_q | d_my_q | ZMag);
      e_st_q  <= norm_shift(d_mtx_q | d_my_q | ZMag);

      f_rd_q.mag[0] <= MagW'(e_mdx_q >> e_sd_q);
      f_rd_q.mag[1] <= MagW'(e_my_q >> e_sd_q);
      f_rd_q.mag[2] <= MagW'(ZMag >> e_sd_q);
      f_rd_q.neg    <= {1'b0, e_ny_q, e_ndx_q};
      f_rt_q.mag[0] <= MagW'(e_mtx_q >> e_st_q);
      f_rt_q.mag[1] <= MagW'(e_my_q >> e_st_q);
      f_rt_q.mag[2] <= MagW'(ZMag >> e_st_q);
      f_rt_q.neg    <= {1'b0, e_ny_q, e_ntx_q};

      for (int j = 0; j < 3; j++) begin
        g_sqd_q[j] <= f_rd_q.mag[j] * f_rd_q.mag[j];
        g_sqt_q[j] <= f_rt_q.mag[j] * f_rt_q.mag[j];
      end
      g_rd_q <= f_rd_q;
      g_rt_q <= f_rt_q;

      h_sumd_q <= 62'(g_sqd_q[0]) + 62'(g_sqd_q[1]) + 62'(g_sqd_q[2]);
      h_sumt_q <= 62'(g_sqt_q[0]) + 62'(g_sqt_q[1]) + 62'(g_sqt_q[2]);
      h_rd_q   <= g_rd_q;
      h_rt_q   <= g_rt_q;

      sqd_q[0]   <= sq_step(sq_init({2'b00, h_sumd_q}));
      sqt_q[0]   <= sq_step(sq_init({2'b00, h_sumt_q}));
      sq_rd_q[0] <= h_rd_q;
      sq_rt_q[0] <= h_rt_q;
      for (int k = 1; k < SqSteps; k++) begin
        sqd_q[k]   <= sq_step(sqd_q[k-1]);
        sqt_q[k]   <= sq_step(sqt_q[k-1]);
        sq_rd_q[k] <= sq_rd_q[k-1];
        sq_rt_q[k] <= sq_rt_q[k-1];
      end

      for (int j = 0; j < 3; j++) begin
        udv_q[0][j]    <= dv_step(dv_init_unit(sq_rd_q[SqSteps-1].mag[j]),
                                  sqd_q[SqSteps-1].root);
        udv_q[0][j+3]  <= dv_step(dv_init_unit(sq_rt_q[SqSteps-1].mag[j]),
                                  sqt_q[SqSteps-1].root);
        uden_q[0][j]   <= sqd_q[SqSteps-1].root;
        uden_q[0][j+3] <= sqt_q[SqSteps-1].root;
      end
      uneg_q[0] <= {sq_rt_q[SqSteps-1].neg, sq_rd_q[SqSteps-1].neg};
      for (int k = 1; k < UnitQ; k++) begin
        for (int l = 0; l < 6; l++) begin
          udv_q[k][l]  <= dv_step(udv_q[k-1][l], uden_q[k-1][l]);
          uden_q[k][l] <= uden_q[k-1][l];
        end
        uneg_q[k] <= uneg_q[k-1];
      end

      for (int j = 0; j < 3; j++) begin
        i_dot_q[j] <= uv[j] * uv[j+3];
        i_mag_q[j] <= uq[j];
      end
      i_neg_q <= uneg_q[UnitQ-1][2:0];

      j_cos_q <= i_dot_q[0] + i_dot_q[1] + i_dot_q[2];
      j_mag_q <= i_mag_q;
      j_neg_q <= i_neg_q;

      k_q.found <= (j_cos_q > lo) && (j_cos_q < hi);
      k_q.c     <= (unsigned'(j_cos_q[63:29]) > CosOne) ? CosOne[31:0] : j_cos_q[60:29];
      k_q.mag   <= j_mag_q;
      k_q.neg   <= j_neg_q;
    end
  end

endmodule

FILE: sv/cstp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstp_fifo: short queue between front and back pipelines
// Register-based FIFO with an occupancy count.
// ----------------------------------------------------------------------------
module cstp_fifo import cstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  fq_t  push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output fq_t  pop_data_o,
  input  logic pop_ready_i
);

  fq_t               mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != FifoCntMax);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntMax)
    else $error("queue count beyond depth");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a lone push");

endmodule

FILE: sv/cstp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstp_back: sine, position scaling and saturation
// Pipelined square root and three dividers; drives the result channel.
// ----------------------------------------------------------------------------
module cstp_back import cstp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  fq_t         q_data_i,
  output logic        q_ready_o,
  cstp_out_if.source  out_if
);

  logic en;

  logic                 b0_vld_q;
  logic [63:0]          b0_cc_q;
  fq_t                  b0_fq_q;
  logic                 b1_vld_q;
  logic [63:0]          b1_rad_q;
  fq_t                  b1_fq_q;

  logic [SqSteps-1:0]   sq_vld_q;
  sq_t                  sq_q   [SqSteps];
  fq_t                  sq_fq_q[SqSteps];

  logic                 b2_vld_q;
  logic [63:0]          b2_num_q [3];
  logic [31:0]          b2_sn_q;
  logic [2:0]           b2_neg_q;
  logic                 b2_found_q;

  logic [PosQ-1:0]      pd_vld_q;
  dv_t                  pdv_q  [PosQ][3];
  logic [31:0]          psn_q  [PosQ];
  logic [2:0]           pneg_q [PosQ];
  logic [2:0]           povf_q [PosQ];
  logic                 pfnd_q [PosQ];

  logic                 o_vld_q;
  logic                 o_found_q;
  logic [PosW-1:0]      o_pos_q [3];

  function automatic logic [PosW-1:0] sat_pos(logic [47:0] q, logic ovf, logic neg,
                                              logic fnd);
    logic [PosW-1:0] r;
    if (!fnd) begin
      r = '0;
    end else if (neg) begin
      r = (ovf || (q > PosMin)) ? PosMin : PosW'(-q);
    end else begin
      r = (ovf || q[PosW-1]) ? PosMax : q;
    end
    return r;
  endfunction

  assign en           = !o_vld_q || out_if.ready;
  assign q_ready_o    = en;
  assign out_if.valid = o_vld_q;
  assign out_if.found = o_found_q;
  assign out_if.pos_x = signed'(o_pos_q[0]);
  assign out_if.pos_y = signed'(o_pos_q[1]);
  assign out_if.pos_z = signed'(o_pos_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_vld_q <= 1'b0;
      b1_vld_q <= 1'b0;
      sq_vld_q <= '0;
      b2_vld_q <= 1'b0;
      pd_vld_q <= '0;
      o_vld_q  <= 1'b0;
    end else if (en) begin
      b0_vld_q <= q_valid_i;
      b1_vld_q <= b0_vld_q;
      sq_vld_q <= {sq_vld_q[SqSteps-2:0], b1_vld_q};
      b2_vld_q <= sq_vld_q[SqSteps-1];
      pd_vld_q <= {pd_vld_q[PosQ-2:0], b2_vld_q};
      o_vld_q  <= pd_vld_q[PosQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_cc_q  <= q_data_i.c * q_data_i.c;
      b0_fq_q  <= q_data_i;
      b1_rad_q <= OneQ62 - b0_cc_q;
      b1_fq_q  <= b0_fq_q;

      sq_q[0]    <= sq_step(sq_init(b1_rad_q));
      sq_fq_q[0] <= b1_fq_q;
      for (int k = 1; k < SqSteps; k++) begin
        sq_q[k]    <= sq_step(sq_q[k-1]);
        sq_fq_q[k] <= sq_fq_q[k-1];
      end

      for (int j = 0; j < 3; j++) begin
        b2_num_q[j] <= {63'(cfg_i.sphere_radius) * 63'(sq_fq_q[SqSteps-1].mag[j]), 1'b0};
      end
      b2_sn_q    <= sq_q[SqSteps-1].root;
      b2_neg_q   <= sq_fq_q[SqSteps-1].neg;
      b2_found_q <= sq_fq_q[SqSteps-1].found && (sq_q[SqSteps-1].root != '0);

      for (int j = 0; j < 3; j++) begin
        pdv_q[0][j]  <= dv_step('{num: {b2_num_q[j][47:0], 16'b0},
                                  rem: {16'b0, b2_num_q[j][63:48]},
                                  quo: '0}, b2_sn_q);
        povf_q[0][j] <= ({16'b0, b2_num_q[j][63:48]} >= b2_sn_q);
      end
      psn_q[0]  <= b2_sn_q;
      pneg_q[0] <= b2_neg_q;
      pfnd_q[0] <= b2_found_q;
      for (int k = 1; k < PosQ; k++) begin
        for (int j = 0; j < 3; j++) begin
          pdv_q[k][j] <= dv_step(pdv_q[k-1][j], psn_q[k-1]);
        end
        psn_q[k]  <= psn_q[k-1];
        pneg_q[k] <= pneg_q[k-1];
        povf_q[k] <= povf_q[k-1];
        pfnd_q[k] <= pfnd_q[k-1];
      end

      o_found_q <= pfnd_q[PosQ-1];
      for (int j = 0; j < 3; j++) begin
        o_pos_q[j] <= sat_pos(pdv_q[PosQ-1][j].quo, povf_q[PosQ-1][j],
                              pneg_q[PosQ-1][j], pfnd_q[PosQ-1]);
      end
    end
  end

  a_zero_when_missed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && !o_found_q) |->
      (o_pos_q[0] == '0 && o_pos_q[1] == '0 && o_pos_q[2] == '0))
    else $error("position nonzero on a missed circle");

endmodule
